@@ design/dobbf_pkg.sv @@
package dobbf_pkg;

   localparam int BUFFER_BYTES = 4096;
   localparam int PTR_W        = $clog2(BUFFER_BYTES);
   localparam int CNT_W        = 13;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EVCHK,
      ST_EVWAIT
   } state_type;

endpackage

@@ design/drop_oldest_byte_budget_fifo.sv @@
// Channel | Direction | Handshake            | Contents
// req     | in        | req_tvalid/tready    | tdata: data_byte, msg_len; tuser: action, msg_start
// rsp     | out       | rsp_tvalid/tready    | tdata: out_byte, counts; tuser: status; tlast: msg_end
// csr     | in        | csr_valid/csr_ready  | csr_data: budget_bytes
//
// A word is accepted in ST_IDLE, then handled in ST_EXEC by a read-modify-write
// against the byte ring and length queue, whose reads are registered. A message
// start also passes through the budget check in ST_EVCHK, and each evicted message
// through ST_EVWAIT as well, as the eviction loop reads each head length.
// Reset is synchronous; the memories are not cleared. The result sits in an output
// register, so a new word is accepted while it waits; only the final commit stalls.
module drop_oldest_byte_budget_fifo
   import dobbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [20:8] msg_len, [23:21] zero
   input  logic [1:0]  req_tuser,   // [0] action, [1] msg_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] out_byte, [20:8] stored_bytes,
                                    // [33:21] stored_messages, [65:34] drop_total,
                                    // [78:66] peak_bytes, [79] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,   // msg_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data     // budget_bytes
);

   localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUFFER_BYTES);

   logic [7:0]       ring_mem [BUFFER_BYTES];
   logic [CNT_W-1:0] lq_mem   [BUFFER_BYTES];

   state_type        state_ff, state_in;
   logic             act_ff, act_in, start_ff, start_in;
   logic [7:0]       byte_ff, byte_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, lwp_ff, lwp_in, lrp_ff, lrp_in;
   logic [CNT_W-1:0] bt_ff, bt_in, msgs_ff, msgs_in, peak_ff, peak_in;
   logic [CNT_W-1:0] inc_ff, inc_in, out_ff, out_in, inc_len_ff, inc_len_in;
   logic [31:0]      drop_ff, drop_in;
   logic [12:0]      budget_ff;
   logic [7:0]       rd_byte_ff;
   logic [CNT_W-1:0] rd_len_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [79:0]      rsp_data_ff, rsp_data_in;
   logic [1:0]       rsp_user_ff, rsp_user_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             ring_we, lq_we, commit, out_free;
   logic [1:0]       res_status;
   logic [7:0]       res_byte;
   logic             res_end;
   logic [CNT_W-1:0] limit, complete, head_left;
   logic [CNT_W-1:0] req_len;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign limit      = (budget_ff < BUF_CNT) ? budget_ff : BUF_CNT;
   assign complete   = msgs_ff - ((inc_ff != '0) ? CNT_W'(1) : CNT_W'(0));
   assign req_len    = req_tdata[20:8];

   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      start_in   = start_ff;
      byte_in    = byte_ff;
      len_in     = len_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      lwp_in     = lwp_ff;
      lrp_in     = lrp_ff;
      bt_in      = bt_ff;
      msgs_in    = msgs_ff;
      peak_in    = peak_ff;
      inc_in     = inc_ff;
      out_in     = out_ff;
      inc_len_in = inc_len_ff;
      drop_in    = drop_ff;
      ring_we    = 1'b0;
      lq_we      = 1'b0;
      commit     = 1'b0;
      res_status = STATUS_OK;
      res_byte   = '0;
      res_end    = 1'b0;
      head_left  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tuser[0];
               start_in = req_tuser[1];
               byte_in  = req_tdata[7:0];
               len_in   = (req_len > BUF_CNT) ? BUF_CNT : req_len;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff == ACT_APPEND) begin
               if (start_ff) begin
                  if (len_ff == '0) begin
                     if (out_free) begin
                        res_status = STATUS_EMPTY;
                        commit     = 1'b1;
                        state_in   = ST_IDLE;
                     end
                  end else begin
                     // An unfinished message is withdrawn without counting a drop.
                     if (inc_ff != '0) begin
                        wp_in   = wp_ff - PTR_W'(inc_len_ff - inc_ff);
                        lwp_in  = lwp_ff - PTR_W'(1);
                        bt_in   = bt_ff - inc_len_ff;
                        msgs_in = msgs_ff - CNT_W'(1);
                        inc_in  = '0;
                     end
                     state_in = ST_EVCHK;
                  end
               end else if (out_free) begin
                  if (inc_ff != '0) begin
                     ring_we = 1'b1;
                     wp_in   = wp_ff + PTR_W'(1);
                     inc_in  = inc_ff - CNT_W'(1);
                  end
                  commit   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (out_free) begin
               if (complete == '0) begin
                  res_status = STATUS_NONE;
               end else begin
                  head_left = ((out_ff == '0) ? rd_len_ff : out_ff) - CNT_W'(1);
                  res_byte  = rd_byte_ff;
                  rp_in     = rp_ff + PTR_W'(1);
                  out_in    = head_left;
                  if (head_left == '0) begin
                     res_end = 1'b1;
                     bt_in   = bt_ff - rd_len_ff;
                     msgs_in = msgs_ff - CNT_W'(1);
                     lrp_in  = lrp_ff + PTR_W'(1);
                  end
               end
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EVCHK: begin
            if (msgs_ff != '0 && ({1'b0, bt_ff} + {1'b0, len_ff}) > {1'b0, limit}) begin
               // A partly popped head skips only its remaining bytes.
               rp_in    = rp_ff + PTR_W'((out_ff != '0) ? out_ff : rd_len_ff);
               out_in   = '0;
               lrp_in   = lrp_ff + PTR_W'(1);
               bt_in    = bt_ff - rd_len_ff;
               msgs_in  = msgs_ff - CNT_W'(1);
               drop_in  = (drop_ff != '1) ? drop_ff + 32'd1 : drop_ff;
               state_in = ST_EVWAIT;
            end else if (out_free) begin
               lq_we      = 1'b1;
               ring_we    = 1'b1;
               lwp_in     = lwp_ff + PTR_W'(1);
               wp_in      = wp_ff + PTR_W'(1);
               bt_in      = bt_ff + len_ff;
               msgs_in    = msgs_ff + CNT_W'(1);
               peak_in    = (bt_in > peak_ff) ? bt_in : peak_ff;
               inc_in     = len_ff - CNT_W'(1);
               inc_len_in = len_ff;
               commit     = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EVWAIT: begin
            state_in = ST_EVCHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = commit ? {1'b0, peak_in, drop_in, msgs_in, bt_in, res_byte}
                            : rsp_data_ff;
      rsp_user_in  = commit ? res_status : rsp_user_ff;
      rsp_last_in  = commit ? res_end : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= byte_ff;
      end
      rd_byte_ff <= ring_mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (lq_we) begin
         lq_mem[lwp_ff] <= len_ff;
      end
      rd_len_ff <= lq_mem[lrp_ff];
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      start_ff    <= start_in;
      byte_ff     <= byte_in;
      len_ff      <= len_in;
      inc_len_ff  <= inc_len_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         lwp_ff       <= '0;
         lrp_ff       <= '0;
         bt_ff        <= '0;
         msgs_ff      <= '0;
         peak_ff      <= '0;
         inc_ff       <= '0;
         out_ff       <= '0;
         drop_ff      <= '0;
         budget_ff    <= 13'd4096;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         lwp_ff       <= lwp_in;
         lrp_ff       <= lrp_in;
         bt_ff        <= bt_in;
         msgs_ff      <= msgs_in;
         peak_ff      <= peak_in;
         inc_ff       <= inc_in;
         out_ff       <= out_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            budget_ff <= csr_data;
         end
      end
   end

endmodule

@@ design/dobbf_checker.sv @@
module dobbf_checker
   import dobbf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result word holds its tdata and tlast.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[78:66] >= rsp_tdata[20:8])
      else $error("peak level below stored bytes");

   a_fail_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_NONE |-> rsp_tdata[7:0] == 8'd0 && !rsp_tlast)
      else $error("failed pop returned data");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_OK || rsp_tuser == STATUS_EMPTY
                     || rsp_tuser == STATUS_NONE)
      else $error("undefined status code");

endmodule

bind drop_oldest_byte_budget_fifo dobbf_checker u_dobbf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
